// File: hdl/simd_multimedia_alu_128_core_defines.svh
// Assertion macros for the multimedia ALU core.
`ifndef SIMD_MULTIMEDIA_ALU_128_CORE_DEFINES_SVH
`define SIMD_MULTIMEDIA_ALU_128_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SMA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/sma_pkg.sv
package sma_pkg;
    localparam int unsigned LANES = 2;

    typedef enum logic [3:0] {
        OP_NONE, OP_SLL, OP_SRL, OP_SRA, OP_SUB, OP_CGT, OP_ADDUS, OP_EXT5,
        OP_AND, OP_OR, OP_XOR, OP_NOR, OP_VSLL, OP_VSRL, OP_VSRA, OP_CPYH
    } t_op;

    typedef enum logic [1:0] {W8, W16, W32} t_width;

    localparam logic [5:0] F_PLZCW = 6'h04, F_MMI0 = 6'h08, F_MMI2 = 6'h09;
    localparam logic [5:0] F_MMI1 = 6'h28, F_MMI3 = 6'h29, F_PSLLH = 6'h34;
    localparam logic [5:0] F_PSRLH = 6'h36, F_PSRAH = 6'h37, F_PSLLW = 6'h3C;
    localparam logic [5:0] F_PSRLW = 6'h3E, F_PSRAW = 6'h3F;

    localparam logic [4:0] S_PSUBW = 5'h01, S_PSUBB = 5'h09, S_PCGTB = 5'h0A;
    localparam logic [4:0] S_PEXTLW = 5'h12, S_PEXTLH = 5'h16, S_PEXT5 = 5'h1E;
    localparam logic [4:0] S_PADDUW = 5'h10, S_PEXTUW = 5'h12, S_PADDUB = 5'h18;
    localparam logic [4:0] S_PSLLVW = 5'h02, S_PSRLVW = 5'h03, S_PCPYLD = 5'h0E;
    localparam logic [4:0] S_PAND = 5'h12, S_PXOR = 5'h13;
    localparam logic [4:0] S_PSRAVW = 5'h03, S_PCPYUD = 5'h0E, S_POR = 5'h12;
    localparam logic [4:0] S_PNOR = 5'h13, S_PCPYH = 5'h1B;

    typedef enum logic [2:0] {
        SRC_LANE, SRC_PLZCW, SRC_EXTLW, SRC_EXTLH, SRC_EXTUW, SRC_CPYLD, SRC_CPYUD
    } t_src;

    typedef struct packed {
        t_op        op;
        t_width     width;
        logic [4:0] sa;
        t_src       src;
        logic       bad;
    } t_ctl;

    // leading copies of the sign bit below bit 31
    function automatic logic [4:0] sign_run(input logic [31:0] v);
        logic [4:0] c;
        logic       stop;
        c = '0;
        stop = 1'b0;
        for (int j = 30; j >= 0; j--) begin
            if (v[j] != v[31]) stop = 1'b1;
            if (!stop) c = c + 5'd1;
        end
        return c;
    endfunction
endpackage

// File: hdl/simd_multimedia_alu_128_core.sv
// Multimedia SIMD ALU. Each word is taken on start and its result appears in the
// next cycle with o_valid high for exactly one cycle; busy never rises, so a
// word can be started every cycle. The result is held in one register stage after the
// lane datapath and merge. The receiver cannot stall and must take every result.
`include "simd_multimedia_alu_128_core_defines.svh"
module simd_multimedia_alu_128_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_instruction,
    input  logic [63:0] i_rs_low,
    input  logic [63:0] i_rs_high,
    input  logic [63:0] i_rt_low,
    input  logic [63:0] i_rt_high,
    output logic        o_valid,
    output logic [4:0]  o_dest_index,
    output logic [63:0] o_result_low,
    output logic [63:0] o_result_high,
    output logic        o_write_low,
    output logic        o_write_high,
    output logic        o_illegal
);
    import sma_pkg::*;

    t_ctl        ctl;
    logic [63:0] lane_y [LANES];
    logic [63:0] n_lo, n_hi;
    logic        n_wl, n_wh;
    logic        r_valid;
    logic [4:0]  r_dest;
    logic [63:0] r_lo, r_hi;
    logic        r_wl, r_wh, r_bad;

    sma_decode u_dec (.i_instruction(i_instruction), .o_ctl(ctl));

    sma_lane u_lane0 (.i_ctl(ctl), .i_a(i_rs_low),  .i_b(i_rt_low),  .o_y(lane_y[0]));
    sma_lane u_lane1 (.i_ctl(ctl), .i_a(i_rs_high), .i_b(i_rt_high), .o_y(lane_y[1]));

    sma_merge u_merge (
        .i_ctl(ctl), .i_lane_lo(lane_y[0]), .i_lane_hi(lane_y[1]),
        .i_rsl(i_rs_low), .i_rsh(i_rs_high), .i_rtl(i_rt_low), .i_rth(i_rt_high),
        .o_lo(n_lo), .o_hi(n_hi), .o_wl(n_wl), .o_wh(n_wh)
    );

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_dest <= i_instruction[15:11];
            r_lo   <= n_lo;
            r_hi   <= n_hi;
            r_wl   <= n_wl;
            r_wh   <= n_wh;
            r_bad  <= ctl.bad;
        end
    end

    assign o_valid       = r_valid;
    assign o_dest_index  = r_dest;
    assign o_result_low  = r_lo;
    assign o_result_high = r_hi;
    assign o_write_low   = r_wl;
    assign o_write_high  = r_wh;
    assign o_illegal     = r_bad;

    `SMA_ASSERT_IMPL(a_bad_no_write, i_clk, i_rst_n, o_valid && o_illegal, !o_write_low && !o_write_high && o_result_low == 64'd0)
    `SMA_ASSERT_NEXT(a_start_valid, i_clk, i_rst_n, start && !busy, o_valid)
    `SMA_ASSERT_IMPL(a_hi_needs_lo, i_clk, i_rst_n, o_valid && o_write_high, o_write_low)
endmodule

// File: hdl/sma_decode.sv
module sma_decode (
    input  logic [31:0]  i_instruction,
    output sma_pkg::t_ctl o_ctl
);
    import sma_pkg::*;

    logic [5:0] funct;
    logic [4:0] sub;

    assign funct = i_instruction[5:0];
    assign sub   = i_instruction[10:6];

    always_comb begin
        o_ctl = '{op: OP_NONE, width: W32, sa: 5'd0, src: SRC_LANE, bad: 1'b0};
        unique case (funct)
            F_PLZCW: o_ctl.src = SRC_PLZCW;
            F_PSLLH: begin o_ctl.op = OP_SLL; o_ctl.width = W16; o_ctl.sa = {1'b0, sub[3:0]}; end
            F_PSRLH: begin o_ctl.op = OP_SRL; o_ctl.width = W16; o_ctl.sa = {1'b0, sub[3:0]}; end
            F_PSRAH: begin o_ctl.op = OP_SRA; o_ctl.width = W16; o_ctl.sa = {1'b0, sub[3:0]}; end
            F_PSLLW: begin o_ctl.op = OP_SLL; o_ctl.sa = sub; end
            F_PSRLW: begin o_ctl.op = OP_SRL; o_ctl.sa = sub; end
            F_PSRAW: begin o_ctl.op = OP_SRA; o_ctl.sa = sub; end
            F_MMI0: begin
                unique case (sub)
                    S_PSUBW:  o_ctl.op = OP_SUB;
                    S_PSUBB:  begin o_ctl.op = OP_SUB; o_ctl.width = W8; end
                    S_PCGTB:  begin o_ctl.op = OP_CGT; o_ctl.width = W8; end
                    S_PEXTLW: o_ctl.src = SRC_EXTLW;
                    S_PEXTLH: o_ctl.src = SRC_EXTLH;
                    S_PEXT5:  o_ctl.op = OP_EXT5;
                    default:  o_ctl.bad = 1'b1;
                endcase
            end
            F_MMI1: begin
                unique case (sub)
                    S_PADDUW: o_ctl.op = OP_ADDUS;
                    S_PEXTUW: o_ctl.src = SRC_EXTUW;
                    S_PADDUB: begin o_ctl.op = OP_ADDUS; o_ctl.width = W8; end
                    default:  o_ctl.bad = 1'b1;
                endcase
            end
            F_MMI2: begin
                unique case (sub)
                    S_PSLLVW: o_ctl.op = OP_VSLL;
                    S_PSRLVW: o_ctl.op = OP_VSRL;
                    S_PCPYLD: o_ctl.src = SRC_CPYLD;
                    S_PAND:   o_ctl.op = OP_AND;
                    S_PXOR:   o_ctl.op = OP_XOR;
                    default:  o_ctl.bad = 1'b1;
                endcase
            end
            F_MMI3: begin
                unique case (sub)
                    S_PSRAVW: o_ctl.op = OP_VSRA;
                    S_PCPYUD: o_ctl.src = SRC_CPYUD;
                    S_POR:    o_ctl.op = OP_OR;
                    S_PNOR:   o_ctl.op = OP_NOR;
                    S_PCPYH:  o_ctl.op = OP_CPYH;
                    default:  o_ctl.bad = 1'b1;
                endcase
            end
            default: o_ctl.bad = 1'b1;
        endcase
    end
endmodule

// File: hdl/sma_lane.sv
// One 64-bit half of the datapath.
module sma_lane (
    input  sma_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic [63:0]   o_y
);
    import sma_pkg::*;

    logic [63:0] r8, r16, r32;
    logic [31:0] vx, vy;
    logic [4:0]  amt;
    logic [8:0]  s8;
    logic [32:0] s32;

    always_comb begin
        r8 = '0;
        s8 = '0;
        for (int i = 0; i < 8; i++) begin
            s8 = {1'b0, i_a[8*i +: 8]} + {1'b0, i_b[8*i +: 8]};
            unique case (i_ctl.op)
                OP_SUB:   r8[8*i +: 8] = i_a[8*i +: 8] - i_b[8*i +: 8];
                OP_CGT:   r8[8*i +: 8] = ($signed(i_a[8*i +: 8]) > $signed(i_b[8*i +: 8]))
                                         ? 8'hFF : 8'h00;
                OP_ADDUS: r8[8*i +: 8] = s8[8] ? 8'hFF : s8[7:0];
                default:  r8[8*i +: 8] = 8'h00;
            endcase
        end
    end

    always_comb begin
        r16 = '0;
        for (int i = 0; i < 4; i++) begin
            unique case (i_ctl.op)
                OP_SLL:  r16[16*i +: 16] = i_b[16*i +: 16] << i_ctl.sa[3:0];
                OP_SRL:  r16[16*i +: 16] = i_b[16*i +: 16] >> i_ctl.sa[3:0];
                OP_SRA:  r16[16*i +: 16] = 16'($signed(i_b[16*i +: 16]) >>> i_ctl.sa[3:0]);
                default: r16[16*i +: 16] = 16'h0;
            endcase
        end
    end

    always_comb begin
        r32 = '0;
        s32 = '0;
        for (int i = 0; i < 2; i++) begin
            s32 = {1'b0, i_a[32*i +: 32]} + {1'b0, i_b[32*i +: 32]};
            unique case (i_ctl.op)
                OP_SLL:   r32[32*i +: 32] = i_b[32*i +: 32] << i_ctl.sa;
                OP_SRL:   r32[32*i +: 32] = i_b[32*i +: 32] >> i_ctl.sa;
                OP_SRA:   r32[32*i +: 32] = 32'($signed(i_b[32*i +: 32]) >>> i_ctl.sa);
                OP_SUB:   r32[32*i +: 32] = i_a[32*i +: 32] - i_b[32*i +: 32];
                OP_ADDUS: r32[32*i +: 32] = s32[32] ? 32'hFFFF_FFFF : s32[31:0];
                OP_EXT5:  r32[32*i +: 32] = {i_b[32*i+15], 7'd0, i_b[32*i+10 +: 5], 3'd0,
                                            i_b[32*i+5 +: 5], 3'd0, i_b[32*i +: 5], 3'd0};
                default:  r32[32*i +: 32] = 32'h0;
            endcase
        end
    end

    assign amt = i_a[4:0];
    assign vx  = i_b[31:0];

    always_comb begin
        unique case (i_ctl.op)
            OP_VSLL: vy = vx << amt;
            OP_VSRL: vy = vx >> amt;
            default: vy = 32'($signed(vx) >>> amt);
        endcase
    end

    always_comb begin
        unique case (i_ctl.op)
            OP_AND:  o_y = i_a & i_b;
            OP_OR:   o_y = i_a | i_b;
            OP_XOR:  o_y = i_a ^ i_b;
            OP_NOR:  o_y = ~(i_a | i_b);
            OP_CPYH: o_y = {4{i_b[15:0]}};
            OP_VSLL, OP_VSRL, OP_VSRA: o_y = {{32{vy[31]}}, vy};
            OP_NONE: o_y = '0;
            default: begin
                unique case (i_ctl.width)
                    W8:      o_y = r8;
                    W16:     o_y = r16;
                    default: o_y = r32;
                endcase
            end
        endcase
    end
endmodule

// File: hdl/sma_merge.sv
// Combines the two lane halves and the cross-lane operations into the result word.
module sma_merge (
    input  sma_pkg::t_ctl i_ctl,
    input  logic [63:0]   i_lane_lo,
    input  logic [63:0]   i_lane_hi,
    input  logic [63:0]   i_rsl,
    input  logic [63:0]   i_rsh,
    input  logic [63:0]   i_rtl,
    input  logic [63:0]   i_rth,
    output logic [63:0]   o_lo,
    output logic [63:0]   o_hi,
    output logic          o_wl,
    output logic          o_wh
);
    import sma_pkg::*;

    always_comb begin
        o_wl = !i_ctl.bad;
        o_wh = !i_ctl.bad;
        unique case (i_ctl.src)
            SRC_PLZCW: begin
                o_lo = {27'd0, sign_run(i_rsl[63:32]), 27'd0, sign_run(i_rsl[31:0])};
                o_hi = '0;
                o_wh = 1'b0;
            end
            SRC_EXTLW: begin
                o_lo = {i_rsl[31:0], i_rtl[31:0]};
                o_hi = {i_rsl[63:32], i_rtl[63:32]};
            end
            SRC_EXTLH: begin
                o_lo = {i_rsl[31:16], i_rtl[31:16], i_rsl[15:0], i_rtl[15:0]};
                o_hi = {i_rsl[63:48], i_rtl[63:48], i_rsl[47:32], i_rtl[47:32]};
            end
            SRC_EXTUW: begin
                o_lo = {i_rsh[31:0], i_rth[31:0]};
                o_hi = {i_rsh[63:32], i_rth[63:32]};
            end
            SRC_CPYLD: begin o_lo = i_rtl; o_hi = i_rsl; end
            SRC_CPYUD: begin o_lo = i_rsh; o_hi = i_rth; end
            default: begin
                o_lo = i_ctl.bad ? 64'd0 : i_lane_lo;
                o_hi = i_ctl.bad ? 64'd0 : i_lane_hi;
            end
        endcase
    end
endmodule

// File: tb/simd_multimedia_alu_128_core_test.sv
`timescale 1ns / 1ps

module simd_multimedia_alu_128_core_test;
    import sma_pkg::*;

    typedef struct {
        logic [31:0] instr;
        logic [63:0] rs_lo, rs_hi, rt_lo, rt_hi;
    } alu_word_t;

    typedef struct {
        logic [4:0]  dest;
        logic [63:0] lo, hi;
        logic        wl, wh, bad;
    } alu_result_t;

    localparam logic [4:0] S_NONE = 5'h00;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_instruction;
    logic [63:0] i_rs_low, i_rs_high, i_rt_low, i_rt_high;
    logic        o_valid;
    logic [4:0]  o_dest_index;
    logic [63:0] o_result_low, o_result_high;
    logic        o_write_low, o_write_high, o_illegal;

    alu_word_t   pending_words[$];
    alu_result_t expected_results[$];
    int          errors;
    int          words_sent;
    int          results_seen;
    int          gap_left;
    bit          stim_done;
    bit          drain_req;

    simd_multimedia_alu_128_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_instruction(i_instruction), .i_rs_low(i_rs_low), .i_rs_high(i_rs_high),
        .i_rt_low(i_rt_low), .i_rt_high(i_rt_high), .o_valid(o_valid),
        .o_dest_index(o_dest_index), .o_result_low(o_result_low),
        .o_result_high(o_result_high), .o_write_low(o_write_low),
        .o_write_high(o_write_high), .o_illegal(o_illegal)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic logic [63:0] lane_op(t_op op, int w, logic [63:0] x,
                                            logic [63:0] y, int sa);
        logic [63:0] m, top, s;
        m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        top = 64'd1 << (w - 1);
        case (op)
            OP_SLL:   return (y << sa) & m;
            OP_SRL:   return y >> sa;
            OP_SRA:   return (y & top) != 0 ? (~((~y & m) >> sa)) & m : (y >> sa);
            OP_SUB:   return (x - y) & m;
            OP_CGT:   return ((x ^ top) > (y ^ top)) ? m : 64'd0;
            OP_ADDUS: begin
                s = x + y;
                return (s > m) ? m : s;
            end
            OP_EXT5:  return ({59'd0, y[4:0]} << 3) | ({59'd0, y[9:5]} << 11)
                             | ({59'd0, y[14:10]} << 19) | ({63'd0, y[15]} << 31);
            OP_AND:   return x & y;
            OP_OR:    return x | y;
            OP_XOR:   return x ^ y;
            OP_NOR:   return ~(x | y);
            default:  return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] half_op(t_op op, int w, logic [63:0] a,
                                            logic [63:0] b, int sa);
        logic [63:0] m, r;
        logic [31:0] x, v;
        int amt;
        r = '0;
        if (op == OP_CPYH) return {4{b[15:0]}};
        if (op == OP_VSLL || op == OP_VSRL || op == OP_VSRA) begin
            amt = a[4:0];
            x = b[31:0];
            if (op == OP_VSLL) v = x << amt;
            else if (op == OP_VSRL) v = x >> amt;
            else v = $signed(x) >>> amt;
            return {{32{v[31]}}, v};
        end
        m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        for (int i = 0; i < 64 / w; i++)
            r |= (lane_op(op, w, (a >> (w * i)) & m, (b >> (w * i)) & m, sa) & m)
                 << (w * i);
        return r;
    endfunction

    function automatic logic [63:0] lead_signs(logic [31:0] v);
        logic [63:0] c;
        c = 0;
        for (int j = 30; j >= 0; j--) begin
            if (v[j] != v[31]) break;
            c++;
        end
        return c;
    endfunction

    function automatic logic [63:0] mix16(logic [63:0] s, logic [63:0] t);
        return {s[31:16], t[31:16], s[15:0], t[15:0]};
    endfunction

    function automatic alu_result_t predict_alu(alu_word_t wd);
        alu_result_t r;
        logic [5:0] fn;
        logic [4:0] sub;
        t_op op;
        int w, sa;
        bit lanes;
        fn = wd.instr[5:0];
        sub = wd.instr[10:6];
        op = OP_NONE; w = 64; sa = 0; lanes = 0;
        r.dest = wd.instr[15:11];
        r.lo = '0; r.hi = '0; r.wl = 1; r.wh = 1; r.bad = 0;
        case (fn)
            F_PLZCW: begin
                r.lo = lead_signs(wd.rs_lo[31:0]) | (lead_signs(wd.rs_lo[63:32]) << 32);
                r.wh = 0;
            end
            F_PSLLH: begin op = OP_SLL; w = 16; sa = sub[3:0]; lanes = 1; end
            F_PSRLH: begin op = OP_SRL; w = 16; sa = sub[3:0]; lanes = 1; end
            F_PSRAH: begin op = OP_SRA; w = 16; sa = sub[3:0]; lanes = 1; end
            F_PSLLW: begin op = OP_SLL; w = 32; sa = sub; lanes = 1; end
            F_PSRLW: begin op = OP_SRL; w = 32; sa = sub; lanes = 1; end
            F_PSRAW: begin op = OP_SRA; w = 32; sa = sub; lanes = 1; end
            F_MMI0: case (sub)
                S_PSUBW:  begin op = OP_SUB; w = 32; lanes = 1; end
                S_PSUBB:  begin op = OP_SUB; w = 8; lanes = 1; end
                S_PCGTB:  begin op = OP_CGT; w = 8; lanes = 1; end
                S_PEXTLW: begin
                    r.lo = {wd.rs_lo[31:0], wd.rt_lo[31:0]};
                    r.hi = {wd.rs_lo[63:32], wd.rt_lo[63:32]};
                end
                S_PEXTLH: begin
                    r.lo = mix16(wd.rs_lo, wd.rt_lo);
                    r.hi = mix16(wd.rs_lo >> 32, wd.rt_lo >> 32);
                end
                S_PEXT5:  begin op = OP_EXT5; w = 32; lanes = 1; end
                default:  r.bad = 1;
            endcase
            F_MMI1: case (sub)
                S_PADDUW: begin op = OP_ADDUS; w = 32; lanes = 1; end
                S_PEXTUW: begin
                    r.lo = {wd.rs_hi[31:0], wd.rt_hi[31:0]};
                    r.hi = {wd.rs_hi[63:32], wd.rt_hi[63:32]};
                end
                S_PADDUB: begin op = OP_ADDUS; w = 8; lanes = 1; end
                default:  r.bad = 1;
            endcase
            F_MMI2: case (sub)
                S_PSLLVW: begin op = OP_VSLL; lanes = 1; end
                S_PSRLVW: begin op = OP_VSRL; lanes = 1; end
                S_PCPYLD: begin r.lo = wd.rt_lo; r.hi = wd.rs_lo; end
                S_PAND:   begin op = OP_AND; lanes = 1; end
                S_PXOR:   begin op = OP_XOR; lanes = 1; end
                default:  r.bad = 1;
            endcase
            F_MMI3: case (sub)
                S_PSRAVW: begin op = OP_VSRA; lanes = 1; end
                S_PCPYUD: begin r.lo = wd.rs_hi; r.hi = wd.rt_hi; end
                S_POR:    begin op = OP_OR; lanes = 1; end
                S_PNOR:   begin op = OP_NOR; lanes = 1; end
                S_PCPYH:  begin op = OP_CPYH; lanes = 1; end
                default:  r.bad = 1;
            endcase
            default: r.bad = 1;
        endcase
        if (lanes) begin
            r.lo = half_op(op, w, wd.rs_lo, wd.rt_lo, sa);
            r.hi = half_op(op, w, wd.rs_hi, wd.rt_hi, sa);
        end
        if (r.bad) begin
            r.lo = '0; r.hi = '0; r.wl = 0; r.wh = 0;
        end
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8000_0000_8000_0000;
            3: v = 64'h7FFF_7FFF_7FFF_7FFF;
            4: v = 64'h8080_8080_8080_8080;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] make_instr(logic [5:0] fn, logic [4:0] sub);
        logic [31:0] v;
        v = $urandom;
        v[5:0] = fn;
        v[10:6] = sub;
        return v;
    endfunction

    task automatic push_word(logic [31:0] ins, logic [63:0] a, logic [63:0] b,
                             logic [63:0] c, logic [63:0] d);
        alu_word_t wd;
        wd.instr = ins; wd.rs_lo = a; wd.rs_hi = b; wd.rt_lo = c; wd.rt_hi = d;
        pending_words.push_back(wd);
    endtask

    logic [5:0] legal_fn[30];
    logic [4:0] legal_sub[30];
    int         n_legal;

    task automatic add_legal(logic [5:0] fn, logic [4:0] sub);
        legal_fn[n_legal] = fn;
        legal_sub[n_legal] = sub;
        n_legal++;
    endtask

    initial begin
        int k;
        errors = 0; words_sent = 0; results_seen = 0; stim_done = 0; drain_req = 0;
        n_legal = 0;
        add_legal(F_PLZCW, S_NONE);  add_legal(F_PSLLH, S_NONE);
        add_legal(F_PSRLH, S_NONE);  add_legal(F_PSRAH, S_NONE);
        add_legal(F_PSLLW, S_NONE);  add_legal(F_PSRLW, S_NONE);
        add_legal(F_PSRAW, S_NONE);
        add_legal(F_MMI0, S_PSUBW);  add_legal(F_MMI0, S_PSUBB);
        add_legal(F_MMI0, S_PCGTB);  add_legal(F_MMI0, S_PEXTLW);
        add_legal(F_MMI0, S_PEXTLH); add_legal(F_MMI0, S_PEXT5);
        add_legal(F_MMI1, S_PADDUW); add_legal(F_MMI1, S_PEXTUW);
        add_legal(F_MMI1, S_PADDUB);
        add_legal(F_MMI2, S_PSLLVW); add_legal(F_MMI2, S_PSRLVW);
        add_legal(F_MMI2, S_PCPYLD); add_legal(F_MMI2, S_PAND);
        add_legal(F_MMI2, S_PXOR);
        add_legal(F_MMI3, S_PSRAVW); add_legal(F_MMI3, S_PCPYUD);
        add_legal(F_MMI3, S_POR);    add_legal(F_MMI3, S_PNOR);
        add_legal(F_MMI3, S_PCPYH);

        // directed: each operation once with mixed extremes
        for (int i = 0; i < n_legal; i++) begin
            logic [4:0] s;
            s = (legal_sub[i] == S_NONE) ? 5'h1F : legal_sub[i];
            push_word(make_instr(legal_fn[i], s), 64'h8000_0001_7FFF_FFFF,
                      64'hFFFF_FFFF_0000_0000, 64'hFFFF_0001_8000_7F80, '1);
        end
        push_word(make_instr(F_MMI0, 5'h00), '1, '1, '1, '1);   // unknown sub-op
        push_word(make_instr(6'h00, 5'h00), '1, '1, '1, '1);    // unknown funct
        push_word(32'h0, '0, '0, '0, '0);
        push_word('1, '1, '1, '1, '1);
        push_word(make_instr(F_PSRAH, 5'h10), '1, '1, 64'h8000_8000_8000_8000, '1);

        // random: mostly legal ops, some anything
        for (int i = 0; i < 2000; i++) begin
            logic [31:0] ins;
            if ($urandom_range(0, 9) < 8) begin
                k = $urandom_range(0, n_legal - 1);
                ins = make_instr(legal_fn[k], legal_sub[k] == S_NONE ?
                                 5'($urandom) : legal_sub[k]);
            end else begin
                ins = $urandom;
            end
            push_word(ins, rand64(), rand64(), rand64(), rand64());
            if (i == 1000) begin
                wait (pending_words.size() == 0);
                drain_req = 1;
                wait (expected_results.size() == 0);
                drain_req = 0;
            end
        end
        wait (pending_words.size() == 0);
        stim_done = 1;
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 7);
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_alu(pending_words.pop_front()));
                words_sent++;
            end
            if (start && !busy) begin
                // word just taken; choose next gap
                if (pending_words.size() > 1 && !drain_req && $urandom_range(0, 3) != 0)
                    gap_left <= $urandom_range(0, 7) * $urandom_range(0, 1);
                else
                    gap_left <= $urandom_range(0, 7);
            end
            if (start && busy) begin
                start <= 1'b1;
            end else if (pending_words.size() > ((start && !busy) ? 0 : 0)
                         && !drain_req && gap_left == 0 && !(start && !busy)) begin
                start <= 1'b1;
                i_instruction <= pending_words[0].instr;
                i_rs_low <= pending_words[0].rs_lo;
                i_rs_high <= pending_words[0].rs_hi;
                i_rt_low <= pending_words[0].rt_lo;
                i_rt_high <= pending_words[0].rt_hi;
            end else if (start && !busy && pending_words.size() > 0 && !drain_req
                         && $urandom_range(0, 1) == 0) begin
                // back-to-back: keep start high
                start <= 1'b1;
                i_instruction <= pending_words[0].instr;
                i_rs_low <= pending_words[0].rs_lo;
                i_rs_high <= pending_words[0].rs_hi;
                i_rt_low <= pending_words[0].rt_lo;
                i_rt_high <= pending_words[0].rt_hi;
            end else begin
                start <= 1'b0;
                if (gap_left > 0 && !(start && !busy)) gap_left <= gap_left - 1;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        alu_result_t e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word dest=%0d lo=%h hi=%h", $time,
                         o_dest_index, o_result_low, o_result_high);
            end else begin
                e = expected_results.pop_front();
                if (o_dest_index !== e.dest || o_result_low !== e.lo ||
                    o_result_high !== e.hi || o_write_low !== e.wl ||
                    o_write_high !== e.wh || o_illegal !== e.bad) begin
                    errors++;
                    $display("%0t: mismatch exp dest=%0d lo=%h hi=%h wl=%b wh=%b ill=%b",
                             $time, e.dest, e.lo, e.hi, e.wl, e.wh, e.bad);
                    $display("%0t:          got dest=%0d lo=%h hi=%h wl=%b wh=%b ill=%b",
                             $time, o_dest_index, o_result_low, o_result_high,
                             o_write_low, o_write_high, o_illegal);
                end
            end
        end
    end

    initial begin
        start = 1'b0;
        i_instruction = '0;
        i_rs_low = '0; i_rs_high = '0; i_rt_low = '0; i_rt_high = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        @(posedge i_clk);
        while (start) @(posedge i_clk);
        wait (expected_results.size() == 0);
        repeat (5) @(posedge i_clk);
        $display("covered %0d words over all supported ops, illegal codes and idle gaps",
                 words_sent);
        $display("%0d result words checked, %0d errors", results_seen, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("simd_multimedia_alu_128_core_test passed");
        else
            $display("simd_multimedia_alu_128_core_test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simd_multimedia_alu_128_core_test failed");
        $finish;
    end
endmodule
